// ===== design/loonn_pkg.sv =====
// Shared constants, types and codes for the leave-one-out nearest neighbor unit.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package loonn_pkg;

    localparam int MAX_ROWS     = 1024;
    localparam int MAX_FEATURES = 16;
    localparam int VALUE_WIDTH  = 16;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);

    localparam int OP_W         = 2;
    localparam int ROW_INDEX_W  = 10;
    localparam int FEAT_INDEX_W = 4;
    localparam int LABEL_W      = 8;
    localparam int DIST_W       = 36;
    localparam int ROWS_CFG_W   = 11;
    localparam int MASK_W       = 16;
    localparam int CFG_INDEX_W  = 1;
    localparam int CFG_DATA_W   = 16;

    localparam int SQ_W       = 2 * VALUE_WIDTH;
    localparam int GROUP_SIZE = 4;
    localparam int GROUPS     = (MAX_FEATURES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PADDED     = GROUPS * GROUP_SIZE;
    localparam int GRP_W      = SQ_W + $clog2(GROUP_SIZE);
    localparam int SUM_W      = GRP_W + $clog2(GROUPS) + 1;

    localparam logic [OP_W-1:0] OP_WRITE_FEATURE = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_LABEL   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY         = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] CFG_ROWS_IN_USE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FEATURE_MASK = 1'b1;

    typedef logic signed [VALUE_WIDTH-1:0] t_value;
    typedef t_value t_row [MAX_FEATURES];

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] idx;
    } t_tag;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_SCAN,
        S_DRAIN,
        S_LABEL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== design/loonn_lane_mem.sv =====
// One feature column of the dataset: a single-port-write, registered-read memory.
// Depends on loonn_pkg for the row count and value width.
`default_nettype none

module loonn_lane_mem (
    input  wire logic                               i_clk,
    input  wire logic                               i_we,
    input  wire logic [loonn_pkg::ROW_W-1:0]       i_waddr,
    input  wire logic [loonn_pkg::VALUE_WIDTH-1:0] i_wdata,
    input  wire logic [loonn_pkg::ROW_W-1:0]       i_raddr,
    output logic      [loonn_pkg::VALUE_WIDTH-1:0] o_rdata
);

    logic [loonn_pkg::VALUE_WIDTH-1:0] r_mem [loonn_pkg::MAX_ROWS];
    logic [loonn_pkg::VALUE_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== design/loonn_dist_pipe.sv =====
// Squared distance pipeline: difference, square, group sums and total, one row per cycle.
// Depends on loonn_pkg for widths, the row type and the item tag.
`default_nettype none

module loonn_dist_pipe (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire loonn_pkg::t_tag              i_tag,
    input  wire loonn_pkg::t_row              i_row,
    input  wire loonn_pkg::t_row              i_query,
    input  wire logic [loonn_pkg::MASK_W-1:0] i_mask,
    output loonn_pkg::t_tag                   o_tag,
    output logic      [loonn_pkg::DIST_W-1:0] o_dist,
    output logic                              o_busy
);

    localparam int VW = loonn_pkg::VALUE_WIDTH;

    logic [loonn_pkg::MAX_FEATURES-1:0] w_lane_on;

    logic [VW-1:0]                    n_b_abs [loonn_pkg::PADDED];
    logic [VW-1:0]                    r_b_abs [loonn_pkg::PADDED];
    logic [loonn_pkg::SQ_W-1:0]       r_c_sq  [loonn_pkg::PADDED];
    logic [loonn_pkg::GRP_W-1:0]      n_d_grp [loonn_pkg::GROUPS];
    logic [loonn_pkg::GRP_W-1:0]      r_d_grp [loonn_pkg::GROUPS];
    logic [loonn_pkg::SUM_W-1:0]      n_e_sum;
    logic [loonn_pkg::DIST_W-1:0]     r_e_dist;

    loonn_pkg::t_tag r_b_tag;
    loonn_pkg::t_tag r_c_tag;
    loonn_pkg::t_tag r_d_tag;
    loonn_pkg::t_tag r_e_tag;

    genvar f;
    generate
        for (f = 0; f < loonn_pkg::MAX_FEATURES; f++) begin : g_lane_on
            if (f < loonn_pkg::MASK_W) begin : g_masked
                assign w_lane_on[f] = i_mask[f];
            end else begin : g_unmasked
                assign w_lane_on[f] = 1'b0;
            end
        end
    endgenerate

    always_comb begin
        logic signed [VW:0] v_diff;
        logic signed [VW:0] v_abs;
        v_diff = '0;
        v_abs  = '0;
        for (int k = 0; k < loonn_pkg::PADDED; k++) begin
            n_b_abs[k] = '0;
        end
        for (int k = 0; k < loonn_pkg::MAX_FEATURES; k++) begin
            v_diff = $signed({i_query[k][VW-1], i_query[k]})
                   - $signed({i_row[k][VW-1], i_row[k]});
            v_abs  = v_diff[VW] ? -v_diff : v_diff;
            n_b_abs[k] = w_lane_on[k] ? v_abs[VW-1:0] : '0;
        end
    end

    always_comb begin
        for (int g = 0; g < loonn_pkg::GROUPS; g++) begin
            n_d_grp[g] = '0;
            for (int j = 0; j < loonn_pkg::GROUP_SIZE; j++) begin
                n_d_grp[g] = n_d_grp[g]
                           + loonn_pkg::GRP_W'(r_c_sq[g * loonn_pkg::GROUP_SIZE + j]);
            end
        end
    end

    always_comb begin
        n_e_sum = '0;
        for (int g = 0; g < loonn_pkg::GROUPS; g++) begin
            n_e_sum = n_e_sum + loonn_pkg::SUM_W'(r_d_grp[g]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
            r_c_tag <= '0;
            r_d_tag <= '0;
            r_e_tag <= '0;
        end else begin
            r_b_tag <= i_tag;
            r_c_tag <= r_b_tag;
            r_d_tag <= r_c_tag;
            r_e_tag <= r_d_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < loonn_pkg::PADDED; k++) begin
            r_b_abs[k] <= n_b_abs[k];
            r_c_sq[k]  <= loonn_pkg::SQ_W'(r_b_abs[k]) * loonn_pkg::SQ_W'(r_b_abs[k]);
        end
        for (int g = 0; g < loonn_pkg::GROUPS; g++) begin
            r_d_grp[g] <= n_d_grp[g];
        end
        r_e_dist <= loonn_pkg::DIST_W'(n_e_sum);
    end

    assign o_tag  = r_e_tag;
    assign o_dist = r_e_dist;
    assign o_busy = r_b_tag.valid | r_c_tag.valid | r_d_tag.valid | r_e_tag.valid;

endmodule

`default_nettype wire

// ===== design/leave_one_out_nearest_neighbor_unit.sv =====
// Top level of the leave-one-out nearest neighbor unit: dataset stores, query sequencer,
// best-match tracking and the output register. Depends on loonn_pkg,
// loonn_lane_mem and loonn_dist_pipe.
//
// A write of a feature value or a class label is stored on the edge that accepts it. A query
// reads the queried row, then streams every other in-use row through one read port of each
// feature column memory, one row per cycle, into a six-stage distance and compare pipeline,
// and finally reads the neighbor's label. The scan of the column memories sets how long a
// query occupies the input, and no further item is taken until its result sits in the output
// register. The result can wait there while later writes are accepted. The stores have no
// reset and need no clearing pass.
`default_nettype none

module leave_one_out_nearest_neighbor_unit (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,

    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic        [loonn_pkg::OP_W-1:0]         i_op,
    input  wire logic        [loonn_pkg::ROW_INDEX_W-1:0]  i_row_index,
    input  wire logic        [loonn_pkg::FEAT_INDEX_W-1:0] i_feature_index,
    input  wire logic signed [loonn_pkg::VALUE_WIDTH-1:0]  i_feature_value,
    input  wire logic        [loonn_pkg::LABEL_W-1:0]      i_class_label,

    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic                                        o_correct,
    output logic             [loonn_pkg::ROW_INDEX_W-1:0]  o_neighbor_index,
    output logic             [loonn_pkg::DIST_W-1:0]       o_best_distance,

    input  wire logic                                   i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  wire logic        [loonn_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic        [loonn_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int ROW_W = loonn_pkg::ROW_W;
    localparam int CNT_W = loonn_pkg::CNT_W;

    loonn_pkg::t_state r_state;
    loonn_pkg::t_state n_state;

    logic [loonn_pkg::ROWS_CFG_W-1:0] r_rows_in_use;
    logic [loonn_pkg::MASK_W-1:0]     r_feature_mask;

    logic             w_in_accept;
    logic             w_row_ok;
    logic             w_feat_we;
    logic             w_label_we;
    logic             w_query_go;
    logic [ROW_W-1:0] w_row_addr;
    logic [ROW_W-1:0] w_raddr;
    logic [ROW_W-1:0] w_label_raddr;
    logic [CNT_W-1:0] w_n_rows;
    logic             w_issue;
    logic             w_out_free;

    logic [loonn_pkg::VALUE_WIDTH-1:0] w_lane_rdata [loonn_pkg::MAX_FEATURES];
    loonn_pkg::t_row                   w_row;
    loonn_pkg::t_row                   r_query_feat;

    logic [loonn_pkg::LABEL_W-1:0] r_label_mem [loonn_pkg::MAX_ROWS];
    logic [loonn_pkg::LABEL_W-1:0] r_label_rdata;
    logic [loonn_pkg::LABEL_W-1:0] r_label_k;

    logic [ROW_W-1:0] r_query_row;
    logic [CNT_W-1:0] r_scan_idx;
    loonn_pkg::t_tag  r_a_tag;

    loonn_pkg::t_tag             w_pipe_tag;
    logic [loonn_pkg::DIST_W-1:0] w_pipe_dist;
    logic                        w_pipe_busy;

    logic                         r_first;
    logic [ROW_W-1:0]             r_best_idx;
    logic [loonn_pkg::DIST_W-1:0] r_best_dist;

    logic                              r_out_valid;
    logic                              r_out_correct;
    logic [loonn_pkg::ROW_INDEX_W-1:0] r_out_index;
    logic [loonn_pkg::DIST_W-1:0]      r_out_dist;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_row_ok    = 32'(i_row_index) < loonn_pkg::MAX_ROWS;
    assign w_row_addr  = ROW_W'(i_row_index);
    assign w_feat_we   = w_in_accept && (i_op == loonn_pkg::OP_WRITE_FEATURE) && w_row_ok
                      && (32'(i_feature_index) < loonn_pkg::MAX_FEATURES);
    assign w_label_we  = w_in_accept && (i_op == loonn_pkg::OP_WRITE_LABEL) && w_row_ok;
    assign w_query_go  = w_in_accept && (i_op == loonn_pkg::OP_QUERY) && w_row_ok;

    assign w_n_rows = (32'(r_rows_in_use) > loonn_pkg::MAX_ROWS)
                    ? CNT_W'(loonn_pkg::MAX_ROWS) : CNT_W'(r_rows_in_use);

    assign w_raddr       = (r_state == loonn_pkg::S_SCAN) ? r_scan_idx[ROW_W-1:0] : w_row_addr;
    assign w_label_raddr = ((r_state == loonn_pkg::S_LABEL) || (r_state == loonn_pkg::S_DONE))
                         ? r_best_idx : w_row_addr;

    assign w_issue = (r_state == loonn_pkg::S_SCAN) && (r_scan_idx < w_n_rows)
                  && (r_scan_idx[ROW_W-1:0] != r_query_row);

    assign w_out_free = !r_out_valid || !i_out_stall;

    genvar f;
    generate
        for (f = 0; f < loonn_pkg::MAX_FEATURES; f++) begin : g_lane
            loonn_lane_mem u_lane_mem (
                .i_clk   (i_clk),
                .i_we    (w_feat_we && (32'(i_feature_index) == f)),
                .i_waddr (w_row_addr),
                .i_wdata (i_feature_value),
                .i_raddr (w_raddr),
                .o_rdata (w_lane_rdata[f])
            );
            assign w_row[f] = $signed(w_lane_rdata[f]);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (w_label_we) begin
            r_label_mem[w_row_addr] <= i_class_label;
        end
        r_label_rdata <= r_label_mem[w_label_raddr];
    end

    loonn_dist_pipe u_dist_pipe (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_a_tag),
        .i_row   (w_row),
        .i_query (r_query_feat),
        .i_mask  (r_feature_mask),
        .o_tag   (w_pipe_tag),
        .o_dist  (w_pipe_dist),
        .o_busy  (w_pipe_busy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= loonn_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        case (r_state)
            loonn_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (w_query_go) begin
                    n_state = loonn_pkg::S_LOAD;
                end
            end
            loonn_pkg::S_LOAD: begin
                n_state = loonn_pkg::S_SCAN;
            end
            loonn_pkg::S_SCAN: begin
                if (r_scan_idx >= w_n_rows) begin
                    n_state = loonn_pkg::S_DRAIN;
                end
            end
            loonn_pkg::S_DRAIN: begin
                if (!r_a_tag.valid && !w_pipe_busy) begin
                    n_state = loonn_pkg::S_LABEL;
                end
            end
            loonn_pkg::S_LABEL: begin
                n_state = loonn_pkg::S_DONE;
            end
            loonn_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = loonn_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = loonn_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_in_use  <= loonn_pkg::ROWS_CFG_W'(1);
            r_feature_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                loonn_pkg::CFG_ROWS_IN_USE: begin
                    r_rows_in_use <= i_cfg_data[loonn_pkg::ROWS_CFG_W-1:0];
                end
                loonn_pkg::CFG_FEATURE_MASK: begin
                    r_feature_mask <= i_cfg_data[loonn_pkg::MASK_W-1:0];
                end
                default: begin
                    r_rows_in_use <= r_rows_in_use;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_idx <= '0;
            r_a_tag    <= '0;
            r_first    <= 1'b1;
        end else begin
            r_a_tag.valid <= w_issue;
            r_a_tag.idx   <= r_scan_idx[ROW_W-1:0];
            if (r_state == loonn_pkg::S_LOAD) begin
                r_scan_idx <= '0;
                r_first    <= 1'b1;
            end else if ((r_state == loonn_pkg::S_SCAN) && (r_scan_idx < w_n_rows)) begin
                r_scan_idx <= r_scan_idx + CNT_W'(1);
            end
            if ((r_state != loonn_pkg::S_LOAD) && w_pipe_tag.valid) begin
                if (r_first || (w_pipe_dist < r_best_dist)) begin
                    r_first <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_query_go) begin
            r_query_row <= w_row_addr;
        end
        if (r_state == loonn_pkg::S_LOAD) begin
            r_query_feat <= w_row;
            r_label_k    <= r_label_rdata;
            r_best_idx   <= '0;
            r_best_dist  <= '0;
        end else if (w_pipe_tag.valid && (r_first || (w_pipe_dist < r_best_dist))) begin
            r_best_idx  <= w_pipe_tag.idx;
            r_best_dist <= w_pipe_dist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == loonn_pkg::S_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == loonn_pkg::S_DONE) && w_out_free) begin
            r_out_correct <= (r_label_k == r_label_rdata);
            r_out_index   <= loonn_pkg::ROW_INDEX_W'(r_best_idx);
            r_out_dist    <= r_best_dist;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_correct        = r_out_correct;
    assign o_neighbor_index = r_out_index;
    assign o_best_distance  = r_out_dist;

    a_pipe_empty_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == loonn_pkg::S_IDLE) |-> (!r_a_tag.valid && !w_pipe_busy))
        else $error("distance pipeline holds a row while no query is running");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == loonn_pkg::S_DONE))
        else $error("result presented outside the final query step");

    a_neighbor_not_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == loonn_pkg::S_LABEL) && !r_first) |-> (r_best_idx != r_query_row))
        else $error("queried row chosen as its own neighbor");

    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == loonn_pkg::S_SCAN) |-> (r_scan_idx <= w_n_rows))
        else $error("row scan ran past the rows in use");

endmodule

`default_nettype wire

// ===== tb/tb_leave_one_out_nearest_neighbor_unit.sv =====
// Self-checking testbench for the leave-one-out nearest neighbor unit.
// It predicts every query result from its own copy of the dataset and the registers.
// Depends on loonn_pkg and leave_one_out_nearest_neighbor_unit.
`timescale 1ns / 100ps

module tb_leave_one_out_nearest_neighbor_unit;

    import loonn_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_CYCLES   = 400;
    localparam int END_LIMIT     = 20000;
    localparam int CYCLE_LIMIT   = 6000000;
    localparam int LOAD_ROWS     = 24;

    typedef struct packed {
        logic                   correct;
        logic [ROW_INDEX_W-1:0] nbr;
        logic [DIST_W-1:0]      distance;
    } t_match;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [OP_W-1:0]           in_op;
    logic [ROW_INDEX_W-1:0]    in_row;
    logic [FEAT_INDEX_W-1:0]   in_feat;
    logic signed [VALUE_WIDTH-1:0] in_value;
    logic [LABEL_W-1:0]        in_label;
    logic                      out_valid;
    logic                      out_stall;
    logic                      out_correct;
    logic [ROW_INDEX_W-1:0]    out_nbr;
    logic [DIST_W-1:0]         out_dist;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    t_value              feat_mem [MAX_ROWS][MAX_FEATURES];
    logic [LABEL_W-1:0]  label_mem [MAX_ROWS];
    logic [ROWS_CFG_W-1:0] row_count;
    logic [MASK_W-1:0]   feat_mask;
    t_match              expected_matches [$];

    int error_count = 0;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit hold_req = 1'b0;

    leave_one_out_nearest_neighbor_unit u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_op            (in_op),
        .i_row_index     (in_row),
        .i_feature_index (in_feat),
        .i_feature_value (in_value),
        .i_class_label   (in_label),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_correct       (out_correct),
        .o_neighbor_index(out_nbr),
        .o_best_distance (out_dist),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_leave_one_out_nearest_neighbor_unit NOT OK");
            $finish;
        end
    end

    task automatic report_mismatch(string what);
        if (error_count < 50) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        end
        error_count++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_value pick_value(int f);
        int     r;
        t_value v;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            return t_value'($urandom);
        end else if (r < 70) begin
            return t_value'($signed($urandom_range(0, 8)) - 4);
        end else if (r < 85) begin
            return ($urandom_range(0, 1) == 1) ? 16'sh7FFF : 16'sh8000;
        end
        v = feat_mem[$urandom_range(0, 15)][f];
        if ($isunknown(v)) begin
            v = t_value'($urandom);
        end
        return v;
    endfunction

    function automatic logic [LABEL_W-1:0] pick_label();
        if ($urandom_range(0, 9) < 7) begin
            return LABEL_W'($urandom_range(0, 3));
        end
        return LABEL_W'($urandom);
    endfunction

    function automatic t_match nearest_row(int k);
        t_match m;
        int     n;
        longint sum;
        longint diff;
        longint best;
        bit     found;
        n = (row_count > MAX_ROWS) ? MAX_ROWS : int'(row_count);
        found = 1'b0;
        best = 0;
        m.nbr = '0;
        for (int i = 0; i < n; i++) begin
            if (i != k) begin
                sum = 0;
                for (int f = 0; f < MAX_FEATURES; f++) begin
                    if (feat_mask[f]) begin
                        diff = longint'(feat_mem[k][f]) - longint'(feat_mem[i][f]);
                        sum += diff * diff;
                    end
                end
                if (!found || sum < best) begin
                    best = sum;
                    m.nbr = ROW_INDEX_W'(i);
                    found = 1'b1;
                end
            end
        end
        m.distance = best[DIST_W-1:0];
        m.correct = (label_mem[k] == label_mem[m.nbr]);
        return m;
    endfunction

    task automatic idle_sender(int n);
        repeat (n) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic send_item(logic [OP_W-1:0] op, int row, int feat, t_value value,
                             logic [LABEL_W-1:0] label, int gap);
        @(negedge clk);
        in_valid <= 1'b1;
        in_op    <= op;
        in_row   <= ROW_INDEX_W'(row);
        in_feat  <= FEAT_INDEX_W'(feat);
        in_value <= value;
        in_label <= label;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        case (op)
            OP_WRITE_FEATURE: feat_mem[row][feat] = value;
            OP_WRITE_LABEL:   label_mem[row] = label;
            OP_QUERY:         expected_matches = {expected_matches, nearest_row(row)};
            default: ;
        endcase
        idle_sender(gap);
    endtask

    task automatic send_query(int row);
        send_item(OP_QUERY, row, $urandom_range(0, 15), t_value'($urandom),
                  LABEL_W'($urandom), steady ? 0 : pick_gap());
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_matches.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        if (idx == CFG_ROWS_IN_USE) begin
            row_count = data[ROWS_CFG_W-1:0];
        end else begin
            feat_mask = data[MASK_W-1:0];
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] rows, logic [MASK_W-1:0] mask);
        drain_results();
        write_reg(CFG_ROWS_IN_USE, rows);
        write_reg(CFG_FEATURE_MASK, mask);
    endtask

    always @(posedge clk) begin : check_results
        t_match m;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
            if (expected_matches.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                m = expected_matches.pop_front();
                if (out_correct !== m.correct) begin
                    report_mismatch($sformatf("correct got %0b want %0b",
                                              out_correct, m.correct));
                end
                if (out_nbr !== m.nbr) begin
                    report_mismatch($sformatf("neighbor_index got %0d want %0d",
                                              out_nbr, m.nbr));
                end
                if (out_dist !== m.distance) begin
                    report_mismatch($sformatf("best_distance got %0d want %0d",
                                              out_dist, m.distance));
                end
            end
        end
    end

    initial begin : rx_pace
        int  run;
        int  hold_left;
        bit  stalling;
        run = 0;
        hold_left = 0;
        stalling = 1'b0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (steady) begin
                run = 0;
                out_stall <= 1'b0;
            end else begin
                if (run == 0) begin
                    stalling = ($urandom_range(0, 2) == 0);
                    run = stalling ? pick_gap() + 1 : $urandom_range(1, 6);
                end
                run--;
                out_stall <= stalling;
            end
        end
    end

    // Rows 0 to 2 hold the value extremes; every other row gets mixed random content.
    task automatic test_load_dataset();
        t_value v;
        logic [LABEL_W-1:0] lab;
        for (int r = 0; r < LOAD_ROWS; r++) begin
            for (int f = 0; f < MAX_FEATURES; f++) begin
                if (r == 0) begin
                    v = 16'sh8000;
                end else if (r < 3) begin
                    v = 16'sh7FFF;
                end else begin
                    v = pick_value(f);
                end
                send_item(OP_WRITE_FEATURE, r, f, v, LABEL_W'($urandom), pick_gap());
            end
            if (r == 0) begin
                lab = 8'h00;
            end else if (r < 3) begin
                lab = 8'hFF;
            end else begin
                lab = pick_label();
            end
            send_item(OP_WRITE_LABEL, r, $urandom_range(0, 15), t_value'($urandom), lab,
                      pick_gap());
        end
    endtask

    task automatic test_reset_settings();
        send_query(0);
        send_query(3);
    endtask

    task automatic test_extreme_distances();
        set_config(3, 16'hFFFF);
        send_query(0);
        send_query(1);
        send_query(2);
        send_item(OP_WRITE_FEATURE, 1, 0, 16'sh0000, 8'h5A, pick_gap());
        send_item(OP_WRITE_LABEL, 1, 7, 16'sh1234, 8'h00, pick_gap());
        send_query(0);
    endtask

    task automatic test_edge_row_counts();
        set_config(0, 16'hFFFF);
        send_query(5);
        set_config(16'hF803, 16'h00F0);
        send_query(20);
        set_config(2047, 16'h0000);
        send_query(7);
        set_config(1024, 16'h0000);
        send_item(OP_WRITE_LABEL, 1023, 0, 16'sh0000, pick_label(), pick_gap());
        send_query(1023);
    endtask

    task automatic test_empty_mask();
        set_config(4, 16'h0000);
        send_query(0);
        send_query(3);
        send_item(OP_UNUSED, 1, 2, 16'sh7FFF, 8'hFF, pick_gap());
        send_query(2);
    endtask

    task automatic test_backpressure();
        set_config(16, 16'hFFFF);
        hold_req = 1'b1;
        for (int j = 0; j < 4; j++) begin
            send_item(OP_QUERY, j * 3, 0, 16'sh0000, 8'h00, 0);
        end
        send_item(OP_WRITE_LABEL, 5, 0, 16'sh0000, pick_label(), 0);
        send_query(9);
        drain_results();
        send_query(1);
        send_query(14);
        drain_results();
    endtask

    task automatic test_random_traffic(int phase);
        int rows;
        int items;
        int lim;
        int r;
        int row;
        logic [MASK_W-1:0] mask;
        items = 15;
        case (phase)
            4: begin
                rows = 1024;
                items = 6;
            end
            7: rows = LOAD_ROWS;
            9: rows = $urandom_range(0, 1);
            default: rows = $urandom_range(2, LOAD_ROWS);
        endcase
        case (phase % 5)
            0: mask = 16'hFFFF;
            2: mask = MASK_W'(1) << $urandom_range(0, 15);
            default: mask = MASK_W'($urandom);
        endcase
        if (rows > LOAD_ROWS) begin
            mask = '0;
        end
        set_config(CFG_DATA_W'(rows), mask);
        steady = (phase % 3 == 1);
        lim = (rows > 1) ? rows : 2;
        for (int j = 0; j < items; j++) begin
            r = $urandom_range(0, 99);
            row = ($urandom_range(0, 9) < 8) ? $urandom_range(0, lim - 1)
                                              : $urandom_range(0, MAX_ROWS - 1);
            if (r < 45) begin
                send_item(OP_WRITE_FEATURE, row, $urandom_range(0, 15),
                          pick_value($urandom_range(0, 15)), LABEL_W'($urandom),
                          steady ? 0 : pick_gap());
            end else if (r < 65) begin
                send_item(OP_WRITE_LABEL, row, $urandom_range(0, 15), t_value'($urandom),
                          pick_label(), steady ? 0 : pick_gap());
            end else if (r < 95) begin
                send_query(row % LOAD_ROWS);
            end else begin
                send_item(OP_UNUSED, row, $urandom_range(0, 15), t_value'($urandom),
                          LABEL_W'($urandom), steady ? 0 : pick_gap());
            end
        end
        drain_results();
        steady = 1'b0;
    endtask

    task automatic finish_run();
        int waited;
        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_matches.size() != 0 && waited < END_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (64) @(posedge clk);
        if (expected_matches.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_matches.size()));
        end
        if (error_count == 0) begin
            $display("tb_leave_one_out_nearest_neighbor_unit OK");
        end else begin
            $display("tb_leave_one_out_nearest_neighbor_unit NOT OK");
        end
        $finish;
    endtask

    initial begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_op     = OP_WRITE_FEATURE;
        in_row    = '0;
        in_feat   = '0;
        in_value  = '0;
        in_label  = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_ROWS_IN_USE;
        cfg_data  = '0;
        row_count = 1;
        feat_mask = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_load_dataset();
        test_reset_settings();
        test_extreme_distances();
        test_edge_row_counts();
        test_empty_mask();
        test_backpressure();
        for (int p = 0; p < 10; p++) begin
            test_random_traffic(p);
        end
        finish_run();
    end

endmodule

// ===== files.f =====
design/loonn_pkg.sv
design/loonn_lane_mem.sv
design/loonn_dist_pipe.sv
design/leave_one_out_nearest_neighbor_unit.sv
tb/tb_leave_one_out_nearest_neighbor_unit.sv
